// ===== rtl/core/bole_pkg.sv =====
package bole_pkg;

    // list geometry
    localparam int DEPTH         = 16;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int ENTRY_COUNT_W = 5;
    localparam int VALUE_W       = 32;

    // command queue between front and back (two slots, power of two)
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // command codes on the input port
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_REMOVE    = 3'd2;
    localparam logic [2:0] CMD_SHOW_FWD  = 3'd3;
    localparam logic [2:0] CMD_SHOW_REV  = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        OP_INS_FRONT,
        OP_INS_BACK,
        OP_REMOVE,
        OP_SHOW_FWD,
        OP_SHOW_REV,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [VALUE_W-1:0]  value;
    } t_task;

    typedef enum logic {
        BS_IDLE,
        BS_SHOW
    } t_bstate;

endpackage

// ===== rtl/core/bole_front.sv =====
module bole_front import bole_pkg::*; (
    input  logic                       i_start,
    input  logic [2:0]                 i_command,
    input  logic signed [VALUE_W-1:0]  i_item_value,
    input  logic                       i_q_full,
    output logic                       o_busy,
    output logic                       o_push,
    output t_task                      o_task
);

    // busy only while the queue has no free slot
    assign o_busy = i_q_full;
    assign o_push = i_start && !i_q_full;

    always_comb begin
        o_task.value = i_item_value;
        case (i_command)
            CMD_INS_FRONT: o_task.op = OP_INS_FRONT;
            CMD_INS_BACK:  o_task.op = OP_INS_BACK;
            CMD_REMOVE:    o_task.op = OP_REMOVE;
            CMD_SHOW_FWD:  o_task.op = OP_SHOW_FWD;
            CMD_SHOW_REV:  o_task.op = OP_SHOW_REV;
            CMD_CLEAR:     o_task.op = OP_CLEAR;
            default:       o_task.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/bole_queue.sv =====
module bole_queue import bole_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_task  i_task,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_task  o_task
);

    t_task              r_slot [QDEPTH];
    logic [QPTR_W-1:0]  r_wp, n_wp;
    logic [QPTR_W-1:0]  r_rp, n_rp;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_task  = r_slot[r_rp];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = w_push ? r_wp + 1'b1 : r_wp;
        n_rp  = w_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_task;
        end
    end

endmodule

// ===== rtl/core/bole_back.sv =====
module bole_back import bole_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  t_task                      i_q_task,
    output logic                       o_q_pop,
    output logic                       o_valid,
    output t_status                    o_status,
    output logic signed [VALUE_W-1:0]  o_entry_value,
    output logic                       o_last,
    output logic [CNT_W-1:0]           o_count
);

    t_bstate                     r_state, n_state;
    logic [IDX_W-1:0]            r_step, n_step;
    logic                        r_rev, n_rev;
    logic [CNT_W-1:0]            r_count, n_count;
    logic signed [VALUE_W-1:0]   r_cells [DEPTH];
    logic signed [VALUE_W-1:0]   n_cells [DEPTH];

    logic                        r_out_valid, n_out_valid;
    t_status                     r_out_status, n_out_status;
    logic signed [VALUE_W-1:0]   r_out_value, n_out_value;
    logic                        r_out_last, n_out_last;
    logic [CNT_W-1:0]            r_out_count, n_out_count;

    logic [DEPTH-1:0]            w_match;
    logic [DEPTH-1:0]            w_below;
    logic [DEPTH-1:0]            w_shift;
    logic                        w_found;
    logic                        w_full;
    logic [IDX_W-1:0]            w_rev_idx;

    // first-match search over the held cells: bits below the lowest match
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = (r_cells[i] == i_q_task.value) && (CNT_W'(i) < r_count);
        end
    end
    assign w_below   = (w_match - DEPTH'(1)) & ~w_match;
    assign w_shift   = ~w_below;
    assign w_found   = |w_match;
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_rev_idx = IDX_W'(DEPTH - 1) - r_step;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid && r_count != '0 &&
                    (i_q_task.op == OP_SHOW_FWD || i_q_task.op == OP_SHOW_REV)) begin
                    n_state = BS_SHOW;
                end
            end
            BS_SHOW: begin
                if (r_step == IDX_W'(DEPTH - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        o_q_pop      = 1'b0;
        n_cells      = r_cells;
        n_count      = r_count;
        n_step       = r_step;
        n_rev        = r_rev;
        n_out_valid  = 1'b0;
        n_out_status = ST_OK;
        n_out_value  = '0;
        n_out_last   = 1'b1;
        n_out_count  = r_count;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    n_out_valid = 1'b1;
                    case (i_q_task.op)
                        OP_INS_FRONT: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (i == 0) begin
                                        n_cells[i] = i_q_task.value;
                                    end else begin
                                        n_cells[i] = r_cells[i-1];
                                    end
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_INS_BACK: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (CNT_W'(i) == r_count) begin
                                        n_cells[i] = i_q_task.value;
                                    end
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (!w_found) begin
                                n_out_status = ST_NOT_FOUND;
                            end else begin
                                for (int i = 0; i < DEPTH - 1; i++) begin
                                    if (w_shift[i]) begin
                                        n_cells[i] = r_cells[i+1];
                                    end
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                        OP_SHOW_FWD, OP_SHOW_REV: begin
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_step      = '0;
                                n_rev       = (i_q_task.op == OP_SHOW_REV);
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_count = n_count;
                end
            end
            BS_SHOW: begin
                // full-length rotation restores the chain after DEPTH steps
                n_step = r_step + 1'b1;
                if (!r_rev) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (i == DEPTH - 1) begin
                            n_cells[i] = r_cells[0];
                        end else begin
                            n_cells[i] = r_cells[i+1];
                        end
                    end
                    n_out_value = r_cells[0];
                    n_out_valid = (CNT_W'(r_step) < r_count);
                    n_out_last  = (CNT_W'(r_step) == r_count - 1'b1);
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (i == 0) begin
                            n_cells[i] = r_cells[DEPTH-1];
                        end else begin
                            n_cells[i] = r_cells[i-1];
                        end
                    end
                    n_out_value = r_cells[DEPTH-1];
                    n_out_valid = (CNT_W'(w_rev_idx) < r_count);
                    n_out_last  = (r_step == IDX_W'(DEPTH - 1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells      <= n_cells;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_last   <= n_out_last;
        r_out_count  <= n_out_count;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_value = r_out_value;
    assign o_last        = r_out_last;
    assign o_count       = r_out_count;

endmodule

// ===== rtl/core/bounded_ordered_list_engine.sv =====
// A non-show result passes the queue slot, then the result register; a show's first result
// also passes the show state; a reverse show sweeps the unused tail cells first. Insert, remove,
// clear, unused codes and an empty show end at the pop; a non-empty show holds the back end
// for the pop, then one full rotation of the chain.
// Two-slot command queue: busy rises only when both slots are taken.
// Reset: i_rst_n synchronous, active low; list emptied, queue flushed; receiver cannot stall.
module bounded_ordered_list_engine import bole_pkg::*; (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [2:0]                        i_command,
    input  logic signed [VALUE_W-1:0]         i_item_value,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic signed [VALUE_W-1:0]         o_entry_value,
    output logic                              o_last,
    output logic [ENTRY_COUNT_W-1:0]          o_entry_count
);

    // front -> queue
    logic    w_push;
    t_task   w_push_task;
    logic    w_q_full;

    // queue -> back
    logic    w_q_valid;
    t_task   w_q_task;
    logic    w_q_pop;

    t_status           w_status;
    logic [CNT_W-1:0]  w_count;

    // front: handshake and command decode
    bole_front u_front (
        .i_start      (i_start),
        .i_command    (i_command),
        .i_item_value (i_item_value),
        .i_q_full     (w_q_full),
        .o_busy       (o_busy),
        .o_push       (w_push),
        .o_task       (w_push_task)
    );

    // short queue decouples acceptance from the long show sweeps
    bole_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_task  (w_push_task),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_task  (w_q_task)
    );

    // back: cell chain holding the list, left aligned, entry 0 is the front
    bole_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_task      (w_q_task),
        .o_q_pop       (w_q_pop),
        .o_valid       (o_valid),
        .o_status      (w_status),
        .o_entry_value (o_entry_value),
        .o_last        (o_last),
        .o_count       (w_count)
    );

    assign o_status      = w_status;
    // count is reported modulo 32 when the list is deeper
    assign o_entry_count = ENTRY_COUNT_W'(w_count);

endmodule
